/* hw/rtl/contact_impulse_solver_core_defines.svh */
// Assertion macros shared by the checker of the contact impulse solver.
// Holds only macro definitions behind an include guard.
`ifndef CONTACT_IMPULSE_SOLVER_CORE_DEFINES_SVH
`define CONTACT_IMPULSE_SOLVER_CORE_DEFINES_SVH
`define CIS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/cis_pkg.sv */
// Types and constants for the contact impulse solver.
// No dependencies.
package cis_pkg;
    localparam logic [1:0] OP_PREPARE = 2'd0;
    localparam logic [1:0] OP_SOLVE   = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [2:0] REG_INV_MASS_A = 3'd0;
    localparam logic [2:0] REG_INV_MASS_B = 3'd1;
    localparam logic [2:0] REG_FRICTION   = 3'd2;
    localparam logic [2:0] REG_NORMAL_X   = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y   = 3'd4;
    localparam logic [2:0] REG_SEPARATION = 3'd5;
    localparam logic [2:0] REG_INV_DT     = 3'd6;
    localparam logic signed [31:0] ALLOWED_PEN = 32'sd6554;
    localparam logic [31:0] BIAS_FACTOR = 32'd13107;

    // Datapath micro-operations issued by the controller.
    typedef enum logic [4:0] {
        U_NOP, U_LOAD, U_DIV_START, U_DIV_STEP, U_BIAS_K, U_BIAS,
        U_WS_NX, U_WS_TX, U_WS_NY, U_WS_TY, U_APPLY_X, U_APPLY_Y,
        U_VN_X, U_VN_Y, U_NACC, U_DN_X, U_DN_Y,
        U_VT_X, U_VT_Y, U_DT, U_MF, U_TACC, U_DT_X, U_DT_Y, U_CLEAR,
        U_AX, U_AY, U_BX, U_BY
    } t_uop;

    typedef struct packed {
        t_uop uop;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;
endpackage

/* hw/rtl/cis_datapath.sv */
// Datapath of the contact solver: registers, one shared multiplier stage
// and a radix-2 divider. Depends on cis_pkg.
module cis_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic [129:0]         i_item,
    input  cis_pkg::t_cmd        i_cmd,
    output cis_pkg::t_status     o_status,
    output logic [127:0]         o_result
);
    import cis_pkg::*;

    logic [30:0] r_ima, r_imb, r_itd;
    logic [18:0] r_fric;
    logic signed [17:0] r_nx, r_ny;
    logic signed [31:0] r_sep;
    logic signed [31:0] r_accn, r_acct, r_meff, r_bias;
    logic signed [31:0] r_v [4];
    logic signed [31:0] r_a, r_b, r_t, r_d;
    logic signed [35:0] r_part;
    logic [32:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0] r_cnt;

    function automatic logic signed [31:0] sat(input logic signed [65:0] x);
        if (x > 66'sd2147483647) return 32'sh7fffffff;
        if (x < -66'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [65:0] qm(input logic signed [32:0] a,
                                              input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    logic signed [65:0] n_prod;
    logic signed [32:0] n_ma, n_mb;
    logic signed [18:0] w_tx, w_ty;
    logic [31:0] w_sum;
    logic signed [32:0] w_pen;

    assign w_tx = 19'(r_ny);
    assign w_ty = -19'(r_nx);
    assign w_sum = {1'b0, r_ima} + {1'b0, r_imb};
    assign w_pen = 33'(r_sep) + 33'(ALLOWED_PEN);

    always_comb begin
        n_ma = '0;
        n_mb = '0;
        case (i_cmd.uop)
            U_BIAS_K: begin n_ma = 33'(BIAS_FACTOR); n_mb = {2'b0, r_itd}; end
            U_BIAS:   begin n_ma = 33'(r_t); n_mb = 33'(r_a); end
            U_WS_NX:  begin n_ma = 33'(r_nx); n_mb = 33'(r_accn); end
            U_WS_TX:  begin n_ma = 33'(w_tx); n_mb = 33'(r_acct); end
            U_WS_NY:  begin n_ma = 33'(r_ny); n_mb = 33'(r_accn); end
            U_WS_TY:  begin n_ma = 33'(w_ty); n_mb = 33'(r_acct); end
            U_AX, U_AY: begin n_ma = 33'((i_cmd.uop == U_AX) ? r_a : r_b);
                          n_mb = {2'b0, r_ima}; end
            U_BX, U_BY: begin n_ma = 33'((i_cmd.uop == U_BX) ? r_a : r_b);
                          n_mb = {2'b0, r_imb}; end
            U_VN_X:   begin n_ma = 33'(r_v[2]) - 33'(r_v[0]); n_mb = 33'(r_nx); end
            U_VN_Y:   begin n_ma = 33'(r_v[3]) - 33'(r_v[1]); n_mb = 33'(r_ny); end
            U_VT_X:   begin n_ma = 33'(r_v[2]) - 33'(r_v[0]); n_mb = 33'(w_tx); end
            U_VT_Y:   begin n_ma = 33'(r_v[3]) - 33'(r_v[1]); n_mb = 33'(w_ty); end
            U_NACC:   begin n_ma = 33'(r_meff);
                          n_mb = 33'(sat(66'(r_bias) - 66'(r_t))); end
            U_DT:     begin n_ma = 33'(r_meff); n_mb = 33'(sat(-66'(r_t))); end
            U_MF:     begin n_ma = {14'b0, r_fric}; n_mb = 33'(r_accn); end
            U_DN_X:   begin n_ma = 33'(r_nx); n_mb = 33'(r_d); end
            U_DN_Y:   begin n_ma = 33'(r_ny); n_mb = 33'(r_d); end
            U_DT_X:   begin n_ma = 33'(w_tx); n_mb = 33'(r_d); end
            U_DT_Y:   begin n_ma = 33'(w_ty); n_mb = 33'(r_d); end
            default: ;
        endcase
        n_prod = qm(n_ma, n_mb);
    end

    logic [32:0] n_rem_sh;
    assign n_rem_sh = {r_rem[31:0], r_quo[32]};
    assign o_status.div_done = (r_cnt == 6'd33);

    logic signed [31:0] w_nacc, w_tacc, w_mfp;
    always_comb begin
        w_nacc = sat(66'(r_accn) + 66'(sat(n_prod)));
        if (w_nacc < 0) w_nacc = '0;
        w_mfp = r_b;
        w_tacc = sat(66'(r_acct) + 66'(sat(n_prod)));
        if (w_tacc > w_mfp) w_tacc = w_mfp;
        if (w_tacc < -w_mfp) w_tacc = -w_mfp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ima <= '0; r_imb <= '0; r_fric <= '0;
            r_nx <= 18'sd65536; r_ny <= '0; r_sep <= '0;
            r_itd <= 31'd3932160;
            r_accn <= '0; r_acct <= '0; r_meff <= '0; r_bias <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_INV_MASS_A: r_ima <= i_cfg_data[30:0];
                    REG_INV_MASS_B: r_imb <= i_cfg_data[30:0];
                    REG_FRICTION:   r_fric <= i_cfg_data[18:0];
                    REG_NORMAL_X:   r_nx <= i_cfg_data[17:0];
                    REG_NORMAL_Y:   r_ny <= i_cfg_data[17:0];
                    REG_SEPARATION: r_sep <= i_cfg_data;
                    REG_INV_DT:     r_itd <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            case (i_cmd.uop)
                U_LOAD: begin
                    r_v[0] <= i_item[33:2];  r_v[1] <= i_item[65:34];
                    r_v[2] <= i_item[97:66]; r_v[3] <= i_item[129:98];
                end
                U_DIV_START: begin
                    r_rem <= '0; r_quo <= 33'h1_0000_0000; r_cnt <= '0;
                    r_t <= (w_pen > 0) ? 32'sd0 : 32'(-w_pen);
                end
                U_DIV_STEP: begin
                    if (r_cnt != 6'd33) begin
                        r_cnt <= r_cnt + 6'd1;
                        if (n_rem_sh >= {1'b0, w_sum}) begin
                            r_rem <= n_rem_sh - {1'b0, w_sum};
                            r_quo <= {r_quo[31:0], 1'b1};
                        end else begin
                            r_rem <= n_rem_sh;
                            r_quo <= {r_quo[31:0], 1'b0};
                        end
                    end else begin
                        if (w_sum == 0) r_meff <= '0;
                        else r_meff <= r_quo[32:31] != 0 ? 32'sh7fffffff : r_quo[31:0];
                    end
                end
                U_BIAS_K: r_a <= n_prod[31:0];
                U_BIAS:   r_bias <= sat(n_prod);
                U_WS_NX:  r_part <= n_prod[35:0];
                U_WS_TX:  r_a <= sat(66'(r_part) + n_prod);
                U_WS_NY:  r_part <= n_prod[35:0];
                U_WS_TY:  r_b <= sat(66'(r_part) + n_prod);
                U_AX: r_v[0] <= sat(66'(r_v[0]) - 66'(sat(n_prod)));
                U_AY: r_v[1] <= sat(66'(r_v[1]) - 66'(sat(n_prod)));
                U_BX: r_v[2] <= sat(66'(r_v[2]) + 66'(sat(n_prod)));
                U_BY: r_v[3] <= sat(66'(r_v[3]) + 66'(sat(n_prod)));
                U_VN_X, U_VT_X: r_part <= n_prod[35:0];
                U_VN_Y, U_VT_Y: r_t <= sat(66'(r_part) + n_prod);
                U_NACC: begin
                    r_d <= w_nacc - r_accn;
                    r_accn <= w_nacc;
                end
                U_DN_X, U_DT_X: r_a <= sat(n_prod);
                U_DN_Y, U_DT_Y: r_b <= sat(n_prod);
                U_MF: r_b <= sat(n_prod);
                U_DT: begin
                    r_d <= w_tacc - r_acct;
                    r_acct <= w_tacc;
                end
                U_CLEAR: begin r_accn <= '0; r_acct <= '0; end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) o_result <= {r_v[3], r_v[2], r_v[1], r_v[0]};
    end
endmodule

/* hw/rtl/cis_controller.sv */
// Sequencer of the contact solver: steps the datapath through one item.
// Depends on cis_pkg.
module cis_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  logic [1:0]        i_op,
    input  logic              i_out_busy,
    input  cis_pkg::t_status  i_status,
    output cis_pkg::t_cmd     o_cmd,
    output logic              o_idle,
    output logic              o_done
);
    import cis_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    logic [2:0] r_state, n_state;
    logic [4:0] r_pc, n_pc;
    logic [1:0] r_op;

    // Micro-programs as uop sequences, ended by U_NOP.
    function automatic t_uop prog(input logic [1:0] op, input logic [4:0] pc);
        t_uop u;
        u = U_NOP;
        if (op == OP_PREPARE) begin
            case (pc)
                5'd0: u = U_BIAS_K;  5'd1: u = U_BIAS;
                5'd2: u = U_WS_NX;   5'd3: u = U_WS_TX;
                5'd4: u = U_WS_NY;   5'd5: u = U_WS_TY;
                5'd6: u = U_AX; 5'd7: u = U_AY; 5'd8: u = U_BX; 5'd9: u = U_BY;
                default: u = U_NOP;
            endcase
        end else if (op == OP_SOLVE) begin
            case (pc)
                5'd0: u = U_VN_X;  5'd1: u = U_VN_Y;  5'd2: u = U_NACC;
                5'd3: u = U_DN_X;  5'd4: u = U_DN_Y;
                5'd5: u = U_AX; 5'd6: u = U_AY; 5'd7: u = U_BX; 5'd8: u = U_BY;
                5'd9: u = U_VT_X;  5'd10: u = U_VT_Y; 5'd11: u = U_MF;
                5'd12: u = U_DT;   5'd13: u = U_DT_X; 5'd14: u = U_DT_Y;
                5'd15: u = U_AX; 5'd16: u = U_AY; 5'd17: u = U_BX; 5'd18: u = U_BY;
                default: u = U_NOP;
            endcase
        end else if (op == OP_CLEAR) begin
            u = (pc == 5'd0) ? U_CLEAR : U_NOP;
        end
        return u;
    endfunction

    t_uop w_u;
    assign w_u = prog(r_op, r_pc);

    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        o_cmd.uop = U_NOP;
        o_cmd.out_load = 1'b0;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: if (i_in_fire) begin
                o_cmd.uop = U_LOAD;
                n_pc = '0;
                n_state = (i_op == OP_PREPARE) ? S_DIV : S_RUN;
            end
            S_DIV: begin
                o_cmd.uop = (r_pc == 5'd0) ? U_DIV_START : U_DIV_STEP;
                n_pc = 5'd1;
                if (r_pc != 5'd0 && i_status.div_done) begin
                    n_pc = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                o_cmd.uop = w_u;
                n_pc = r_pc + 5'd1;
                if (w_u == U_NOP) n_state = S_OUT;
            end
            S_OUT: if (!i_out_busy) begin
                o_cmd.out_load = 1'b1;
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idle = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc <= '0;
            r_op <= '0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
            if (i_in_fire) r_op <= i_op;
        end
    end
endmodule

/* hw/rtl/contact_impulse_solver_core.sv */
// Top level of the 2D contact impulse solver in Q16.16 fixed point.
// Depends on cis_pkg, cis_controller and cis_datapath.
// One item is taken at a time. How soon the next item can be accepted is set by the
// single shared multiplier stage and the one-bit-per-cycle divider for the effective
// mass; a result held by the output side adds its stall before the next acceptance.
// The result register lets the next item enter while a result waits.
module contact_impulse_solver_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op, vel_a_x, vel_a_y, vel_b_x, vel_b_y from bit 0 up, zero filled.
    input  logic [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y from bit 0 up.
    output logic [127:0] m_axis_tdata
);
    import cis_pkg::*;

    t_cmd w_cmd;
    t_status w_status;
    logic w_idle, w_done, w_fire, r_valid;

    assign s_axis_tready = w_idle;
    assign w_fire = s_axis_tvalid && s_axis_tready;

    cis_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_fire(w_fire),
        .i_op(s_axis_tdata[1:0]), .i_out_busy(r_valid && !m_axis_tready),
        .i_status(w_status), .o_cmd(w_cmd), .o_idle(w_idle), .o_done(w_done)
    );

    cis_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_item(s_axis_tdata[129:0]), .i_cmd(w_cmd), .o_status(w_status),
        .o_result(m_axis_tdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (w_done) r_valid <= 1'b1;
        else if (m_axis_tready) r_valid <= 1'b0;
    end
    assign m_axis_tvalid = r_valid;
endmodule

/* hw/rtl/cis_checker.sv */
// Port-level checker for the contact solver, bound to the top level.
// Depends on contact_impulse_solver_core_defines.svh.
`include "contact_impulse_solver_core_defines.svh"
module cis_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready
);
    `CIS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CIS_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CIS_ASSERT_NEXT(a_no_out_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)
endmodule

bind contact_impulse_solver_core cis_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
);
